### src/blt_pkg.sv
package blt_pkg;

    // Token kinds as carried in the result
    typedef enum logic [2:0] {
        KIND_EOF     = 3'd0,
        KIND_UNKNOWN = 3'd1,
        KIND_PRINT   = 3'd2,
        KIND_ADD     = 3'd3,
        KIND_MULT    = 3'd4,
        KIND_STRING  = 3'd5,
        KIND_NUMBER  = 3'd6
    } kind_t;

    // Scanner mode, one-hot
    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_STRING = 4'b0010,
        MODE_WORD   = 4'b0100,
        MODE_NUMBER = 4'b1000
    } mode_t;

    localparam int OFFSET_W   = 16;
    localparam int MAX_BURST  = 3;
    localparam int KEYWORD_LEN = 5;

    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        kind_t                 kind;
        logic [OFFSET_W-1:0]   start_offset;
        logic [OFFSET_W-1:0]   token_length;
        logic                  last_of_run;
    } result_t;

    // All results caused by one input item
    typedef struct packed {
        logic [1:0]                   count;
        result_t [MAX_BURST-1:0]      slot;
    } burst_t;

    function automatic logic [OFFSET_W-1:0] sat_inc(input logic [OFFSET_W-1:0] v);
        sat_inc = (v == '1) ? v : v + OFFSET_W'(1);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == CHAR_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        upcase = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    endfunction

    // Letters of the PRINT keyword
    function automatic logic [7:0] keyword_char(input logic [2:0] idx);
        case (idx)
            3'd0:    keyword_char = 8'h50;
            3'd1:    keyword_char = 8'h52;
            3'd2:    keyword_char = 8'h49;
            3'd3:    keyword_char = 8'h4E;
            3'd4:    keyword_char = 8'h54;
            default: keyword_char = 8'h00;
        endcase
    endfunction

    // Kind of the token that is open in the given mode
    function automatic kind_t close_kind(input mode_t m, input logic kw,
                                         input logic [OFFSET_W-1:0] len);
        if (m == MODE_STRING)
            close_kind = KIND_STRING;
        else if (m == MODE_NUMBER)
            close_kind = KIND_NUMBER;
        else if (kw && len == OFFSET_W'(KEYWORD_LEN))
            close_kind = KIND_PRINT;
        else
            close_kind = KIND_UNKNOWN;
    endfunction

    function automatic result_t make_result(input kind_t k,
                                            input logic [OFFSET_W-1:0] s,
                                            input logic [OFFSET_W-1:0] l);
        make_result.kind         = k;
        make_result.start_offset = s;
        make_result.token_length = l;
        make_result.last_of_run  = 1'b0;
    endfunction

endpackage

### src/blt_scanner.sv
module blt_scanner #(
    parameter int MAX_TEXT_BYTES = 65536
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take_item,
    input  logic [7:0]      text_byte,
    input  logic            byte_present,
    input  logic            end_of_text,
    output blt_pkg::burst_t burst
);
    import blt_pkg::*;

    localparam int TAKEN_W = $clog2(MAX_TEXT_BYTES + 1);

    mode_t               mode_reg,   mode_next;
    logic [OFFSET_W-1:0] pos_reg,    pos_next;
    logic [OFFSET_W-1:0] start_reg,  start_next;
    logic [OFFSET_W-1:0] len_reg,    len_next;
    logic                kw_reg,     kw_next;
    logic [TAKEN_W-1:0]  taken_reg,  taken_next;

    result_t    res [0:MAX_BURST-1];
    logic [1:0] n;
    logic [1:0] idx_last;
    logic       take;
    logic       idle_start;

    // Next state and the results of this item
    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        len_next   = len_reg;
        kw_next    = kw_reg;
        taken_next = taken_reg;
        n          = 2'd0;
        idx_last   = 2'd0;
        idle_start = 1'b0;
        for (int i = 0; i < MAX_BURST; i++)
        begin
            res[i] = '0;
        end

        take = byte_present && (taken_reg < TAKEN_W'(MAX_TEXT_BYTES));

        if (take)
        begin
            unique case (mode_reg)
                MODE_STRING:
                begin
                    if (text_byte == CHAR_QUOTE)
                    begin
                        res[n] = make_result(KIND_STRING, start_reg, len_reg);
                        n = n + 2'd1;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        len_next = sat_inc(len_reg);
                    end
                end
                MODE_WORD:
                begin
                    if (text_byte == CHAR_SPACE)
                    begin
                        res[n] = make_result(close_kind(MODE_WORD, kw_reg, len_reg),
                                             start_reg, len_reg);
                        n = n + 2'd1;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        if (len_reg < OFFSET_W'(KEYWORD_LEN))
                            kw_next = kw_reg &&
                                      (upcase(text_byte) == keyword_char(len_reg[2:0]));
                        else
                            kw_next = 1'b0;
                        len_next = sat_inc(len_reg);
                    end
                end
                MODE_NUMBER:
                begin
                    if (is_digit(text_byte))
                    begin
                        len_next = sat_inc(len_reg);
                    end
                    else
                    begin
                        res[n] = make_result(KIND_NUMBER, start_reg, len_reg);
                        n = n + 2'd1;
                        mode_next  = MODE_IDLE;
                        idle_start = 1'b1;
                    end
                end
                MODE_IDLE:
                begin
                    idle_start = 1'b1;
                end
                default:
                begin
                    idle_start = 1'b1;
                end
            endcase

            // Byte seen with no open token
            if (idle_start)
            begin
                if (is_blank(text_byte))
                begin
                    mode_next = MODE_IDLE;
                end
                else if (text_byte == CHAR_QUOTE)
                begin
                    mode_next  = MODE_STRING;
                    start_next = sat_inc(pos_reg);
                    len_next   = '0;
                end
                else if (is_letter(text_byte))
                begin
                    mode_next  = MODE_WORD;
                    start_next = pos_reg;
                    len_next   = OFFSET_W'(1);
                    kw_next    = (upcase(text_byte) == keyword_char(3'd0));
                end
                else if (is_digit(text_byte))
                begin
                    mode_next  = MODE_NUMBER;
                    start_next = pos_reg;
                    len_next   = OFFSET_W'(1);
                end
                else if (text_byte == CHAR_STAR)
                begin
                    res[n] = make_result(KIND_MULT, pos_reg, OFFSET_W'(1));
                    n = n + 2'd1;
                end
                else if (text_byte == CHAR_PLUS)
                begin
                    res[n] = make_result(KIND_ADD, pos_reg, OFFSET_W'(1));
                    n = n + 2'd1;
                end
            end

            pos_next   = sat_inc(pos_reg);
            taken_next = taken_reg + TAKEN_W'(1);
        end

        // End of text: flush, EOF, back to reset values
        if (end_of_text)
        begin
            if (mode_next != MODE_IDLE)
            begin
                res[n] = make_result(close_kind(mode_next, kw_next, len_next),
                                     start_next, len_next);
                n = n + 2'd1;
            end
            res[n] = make_result(KIND_EOF, pos_next, '0);
            n = n + 2'd1;
            mode_next  = MODE_IDLE;
            pos_next   = '0;
            start_next = '0;
            len_next   = '0;
            kw_next    = 1'b0;
            taken_next = '0;
        end

        if (n != 2'd0)
        begin
            idx_last = n - 2'd1;
            res[idx_last].last_of_run = 1'b1;
        end
    end

    // Pack the burst for the result queue
    always_comb
    begin
        burst.count = n;
        for (int i = 0; i < MAX_BURST; i++)
        begin
            burst.slot[i] = res[i];
        end
    end

    // Scanner state, updated on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            kw_reg    <= 1'b0;
            taken_reg <= '0;
        end
        else if (take_item)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            kw_reg    <= kw_next;
            taken_reg <= taken_next;
        end
    end

endmodule

### src/blt_result_queue.sv
module blt_result_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  blt_pkg::burst_t  burst,
    output logic             load_ready,
    output blt_pkg::result_t head,
    output logic             head_valid,
    input  logic             head_ready
);
    import blt_pkg::*;

    result_t    q_reg [0:MAX_BURST-1];
    logic [1:0] cnt_reg;
    logic       pop;

    // Head transfer, and room for a new burst
    assign pop        = (cnt_reg != 2'd0) && head_ready;
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_reg[0];
    assign load_ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && head_ready);

    // Result slots: load all at once, shift down on each transfer
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < MAX_BURST; i++)
            begin
                q_reg[i] <= burst.slot[i];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_BURST - 1; i++)
            begin
                q_reg[i] <= q_reg[i+1];
            end
        end
    end

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (load)
            cnt_reg <= burst.count;
        else if (pop)
            cnt_reg <= cnt_reg - 2'd1;
    end

endmodule

### src/basic_token_lexer_core.sv
// Channel   Direction  Fields
// s_axis    in         tdata: text_byte; tuser: byte_present; tlast: end_of_text
// m_axis    out        tdata: start_offset, token_length; tuser: token_kind;
//                      tlast: last_of_run
//
// One input byte per cycle while m_axis accepts and each item gives at most one
// token; an item that gives two or three tokens stalls the input while the result
// queue drains them. Scanner state updates on the input transfer; results are
// registered in the result queue before they leave. Reset clears scanner
// state and the queue count. s_axis is ready only when the queue is empty or its
// single token leaves in the same cycle, so an m_axis stall reaches s_axis at once.
module basic_token_lexer_core #(
    parameter int MAX_TEXT_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] start_offset, [31:16] token_length
    output logic [2:0]  m_axis_tuser,   // [2:0] token_kind
    output logic        m_axis_tlast    // last_of_run
);
    import blt_pkg::*;

    burst_t  burst;
    result_t head;
    logic    take_item;

    assign take_item = s_axis_tvalid && s_axis_tready;

    // Tokenizer state and per-byte decode
    blt_scanner #(
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
    ) u_scanner (
        .clk          (clk),
        .rst_n        (rst_n),
        .take_item    (take_item),
        .text_byte    (s_axis_tdata),
        .byte_present (s_axis_tuser),
        .end_of_text  (s_axis_tlast),
        .burst        (burst)
    );

    // Result registers and serializer
    blt_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take_item),
        .burst      (burst),
        .load_ready (s_axis_tready),
        .head       (head),
        .head_valid (m_axis_tvalid),
        .head_ready (m_axis_tready)
    );

    // Output packing
    assign m_axis_tdata = {head.token_length, head.start_offset};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last_of_run;

endmodule
